// ===== rtl/rm2q_pkg.sv =====
// ----------------------------------------------------------------------------
// rm2q_pkg
// Shared types and constants for the rotation matrix to quaternion block.
// ----------------------------------------------------------------------------
package rm2q_pkg;

  localparam int FRAC_BITS = 16;
  localparam int INT_BITS  = 4;
  localparam int W         = INT_BITS + FRAC_BITS;

  // square root digit count and pipeline depth
  localparam int PAIRS     = (W + 3 + FRAC_BITS) / 2;
  localparam int QBITS     = 2 * FRAC_BITS;
  localparam int LATENCY   = 1 + PAIRS + 1 + QBITS + 2;

  // branch codes: which component takes the diagonal term
  localparam logic [1:0] BR_X = 2'd0;
  localparam logic [1:0] BR_Y = 2'd1;
  localparam logic [1:0] BR_Z = 2'd2;
  localparam logic [1:0] BR_W = 2'd3;

  typedef struct packed {
    logic signed [W-1:0] mat_e0;
    logic signed [W-1:0] mat_e1;
    logic signed [W-1:0] mat_e2;
    logic signed [W-1:0] mat_e4;
    logic signed [W-1:0] mat_e5;
    logic signed [W-1:0] mat_e6;
    logic signed [W-1:0] mat_e8;
    logic signed [W-1:0] mat_e9;
    logic signed [W-1:0] mat_e10;
  } mat_t;

  typedef struct packed {
    logic signed [W-1:0] quat_x;
    logic signed [W-1:0] quat_y;
    logic signed [W-1:0] quat_z;
    logic signed [W-1:0] quat_w;
    logic                invalid;
  } quat_t;

endpackage

// ===== rtl/rotation_matrix_to_quaternion.sv =====
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion
// Four-branch trace method, fixed point, fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
//   Drive mat_i and raise start_i; the item is taken at that edge since
//   busy_o is always low. One item may enter every cycle.
//   Each result shows on quat_o (Q4.16) for one cycle with done_o high,
//   after one front stage, one stage per square root digit pair, one
//   divider load stage, one stage per reciprocal quotient bit, one
//   multiply stage and one output stage.
//   Throughput is one item per cycle, set by the fully unrolled digit
//   pipelines of the square root and the restoring divider.
//   Results leave in the order items entered. The receiver cannot stall
//   the block; a result not taken in its cycle is gone.
//   Reset clears all valid bits, so no result appears until a new item
//   has passed the whole pipeline.
//   invalid marks a non-positive radicand; all four components are zero.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion
  import rm2q_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  start_i,
  output logic  busy_o,
  input  mat_t  mat_i,
  output logic  done_o,
  output quat_t quat_o
);

  localparam int RW   = W + 1;
  localparam int RADW = 2 * PAIRS;
  localparam int SW   = W + 3;
  localparam int PW   = RW + QBITS;

  typedef struct packed {
    logic [1:0]        branch;
    logic              inv;
    logic [RADW-1:0]   rad;
    logic [PAIRS-1:0]  diag;
    logic [2:0][RW-1:0] dmag;
    logic [2:0]        dneg;
  } side_t;

  assign busy_o = 1'b0;

  // front stage
  logic signed [SW-1:0] e0, e1, e2, e4, e5, e6, e8, e9, e10;
  logic signed [SW-1:0] trace, r, one;
  logic signed [SW-1:0] d_a, d_b, d_c;
  side_t                front_d;

  always_comb begin
    e0  = SW'(mat_i.mat_e0);
    e1  = SW'(mat_i.mat_e1);
    e2  = SW'(mat_i.mat_e2);
    e4  = SW'(mat_i.mat_e4);
    e5  = SW'(mat_i.mat_e5);
    e6  = SW'(mat_i.mat_e6);
    e8  = SW'(mat_i.mat_e8);
    e9  = SW'(mat_i.mat_e9);
    e10 = SW'(mat_i.mat_e10);
    one = SW'(1) <<< FRAC_BITS;
    trace = e0 + e5 + e10;
    front_d = '0;
    if (trace > 0) begin
      front_d.branch = BR_W;
      r   = trace + one;
      d_a = e6 - e9;
      d_b = e8 - e2;
      d_c = e1 - e4;
    end else if (e0 >= e5 && e0 >= e10) begin
      front_d.branch = BR_X;
      r   = one + e0 - e5 - e10;
      d_a = e1 + e4;
      d_b = e2 + e8;
      d_c = e6 - e9;
    end else if (e5 > e10) begin
      front_d.branch = BR_Y;
      r   = one + e5 - e0 - e10;
      d_a = e4 + e1;
      d_b = e9 + e6;
      d_c = e8 - e2;
    end else begin
      front_d.branch = BR_Z;
      r   = one + e10 - e0 - e5;
      d_a = e8 + e2;
      d_b = e9 + e6;
      d_c = e1 - e4;
    end
    front_d.inv     = (r <= 0);
    front_d.rad     = RADW'({r[RW-1:0], {FRAC_BITS{1'b0}}});
    front_d.dneg[0] = d_a[SW-1];
    front_d.dneg[1] = d_b[SW-1];
    front_d.dneg[2] = d_c[SW-1];
    front_d.dmag[0] = RW'(d_a[SW-1] ? -d_a : d_a);
    front_d.dmag[1] = RW'(d_b[SW-1] ? -d_b : d_b);
    front_d.dmag[2] = RW'(d_c[SW-1] ? -d_c : d_c);
  end

  // square root pipeline
  logic             sq_vld_q  [PAIRS+1];
  side_t            sq_side_q [PAIRS+1];
  logic [PAIRS+1:0] sq_rem_q  [PAIRS+1];
  logic [PAIRS-1:0] sq_root_q [PAIRS+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_vld_q[0] <= 1'b0;
    end else begin
      sq_vld_q[0] <= start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    sq_side_q[0] <= front_d;
    sq_rem_q[0]  <= '0;
    sq_root_q[0] <= '0;
  end

  for (genvar s = 0; s < PAIRS; s++) begin : g_sqrt
    localparam int K = PAIRS - 1 - s;
    logic [PAIRS+1:0] rem_n, trial;
    logic             ge;
    assign rem_n = {sq_rem_q[s][PAIRS-1:0], sq_side_q[s].rad[2*K+1 -: 2]};
    assign trial = {sq_root_q[s], 2'b01};
    assign ge    = (rem_n >= trial);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sq_vld_q[s+1] <= 1'b0;
      end else begin
        sq_vld_q[s+1] <= sq_vld_q[s];
      end
    end

    always_ff @(posedge clk_i) begin
      sq_side_q[s+1] <= sq_side_q[s];
      sq_rem_q[s+1]  <= ge ? rem_n - trial : rem_n;
      sq_root_q[s+1] <= {sq_root_q[s][PAIRS-2:0], ge};
    end
  end

  // reciprocal pipeline: 2^(2F-1) / root
  logic             dv_vld_q  [QBITS+1];
  side_t            dv_side_q [QBITS+1];
  logic [PAIRS:0]   dv_rem_q  [QBITS+1];
  logic [PAIRS-1:0] dv_den_q  [QBITS+1];
  logic [QBITS-1:0] dv_quo_q  [QBITS+1];
  side_t            sq_out;

  always_comb begin
    sq_out      = sq_side_q[PAIRS];
    sq_out.diag = sq_root_q[PAIRS] >> 1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_vld_q[0] <= 1'b0;
    end else begin
      dv_vld_q[0] <= sq_vld_q[PAIRS];
    end
  end

  always_ff @(posedge clk_i) begin
    dv_side_q[0] <= sq_out;
    dv_rem_q[0]  <= '0;
    dv_den_q[0]  <= sq_root_q[PAIRS];
    dv_quo_q[0]  <= '0;
  end

  for (genvar t = 0; t < QBITS; t++) begin : g_div
    logic [PAIRS:0] rem_n, den;
    logic           ge;
    assign rem_n = {dv_rem_q[t][PAIRS-1:0], (t == 0) ? 1'b1 : 1'b0};
    assign den   = {1'b0, dv_den_q[t]};
    assign ge    = (rem_n >= den);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_vld_q[t+1] <= 1'b0;
      end else begin
        dv_vld_q[t+1] <= dv_vld_q[t];
      end
    end

    always_ff @(posedge clk_i) begin
      dv_side_q[t+1] <= dv_side_q[t];
      dv_den_q[t+1]  <= dv_den_q[t];
      dv_rem_q[t+1]  <= ge ? rem_n - den : rem_n;
      dv_quo_q[t+1]  <= {dv_quo_q[t][QBITS-2:0], ge};
    end
  end

  // multiply stage
  logic              mul_vld_q;
  side_t             mul_side_q;
  logic [2:0][PW-1:0] mul_prod_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_vld_q <= 1'b0;
    end else begin
      mul_vld_q <= dv_vld_q[QBITS];
    end
  end

  always_ff @(posedge clk_i) begin
    mul_side_q <= dv_side_q[QBITS];
    for (int l = 0; l < 3; l++) begin
      mul_prod_q[l] <= PW'(dv_side_q[QBITS].dmag[l]) * PW'(dv_quo_q[QBITS]);
    end
  end

  // saturate and place components
  localparam logic [PW-1:0] POS_MAX = PW'((64'd1 << (W - 1)) - 64'd1);
  localparam logic [PW-1:0] NEG_MAG = PW'(64'd1 << (W - 1));

  logic [3:0][W-1:0] comp;
  logic [2:0][W-1:0] lane;
  quat_t             quat_d;

  always_comb begin
    logic [PW-1:0] q;
    for (int l = 0; l < 3; l++) begin
      q = mul_prod_q[l] >> FRAC_BITS;
      if (mul_side_q.dneg[l]) begin
        lane[l] = (q >= NEG_MAG) ? W'(NEG_MAG) : W'(-q);
      end else begin
        lane[l] = (q > POS_MAX) ? W'(POS_MAX) : W'(q);
      end
    end
    for (int i = 0; i < 4; i++) begin
      if (2'(i) == mul_side_q.branch) begin
        comp[i] = (PW'(mul_side_q.diag) > POS_MAX) ? W'(POS_MAX) : W'(mul_side_q.diag);
      end else if (2'(i) < mul_side_q.branch) begin
        comp[i] = lane[i];
      end else begin
        comp[i] = lane[i-1];
      end
    end
    quat_d.quat_x  = comp[0];
    quat_d.quat_y  = comp[1];
    quat_d.quat_z  = comp[2];
    quat_d.quat_w  = comp[3];
    quat_d.invalid = mul_side_q.inv;
    if (mul_side_q.inv) begin
      quat_d = '0;
      quat_d.invalid = 1'b1;
    end
  end

  logic  done_q;
  quat_t quat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= mul_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    quat_q <= quat_d;
  end

  assign done_o = done_q;
  assign quat_o = quat_q;

endmodule

// ===== rtl/rm2q_checker.sv =====
// ----------------------------------------------------------------------------
// rm2q_checker
// Port-level checks for rotation_matrix_to_quaternion.
// ----------------------------------------------------------------------------
module rm2q_checker
  import rm2q_pkg::*;
(
  input logic  clk_i,
  input logic  rst_ni,
  input logic  start_i,
  input logic  busy_o,
  input mat_t  mat_i,
  input logic  done_o,
  input quat_t quat_o
);

  logic signed [W+1:0] trace;
  assign trace = (W+2)'(mat_i.mat_e0) + (W+2)'(mat_i.mat_e5) + (W+2)'(mat_i.mat_e10);

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |-> ##LATENCY done_o)
    else $error("item did not complete at fixed latency");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i, LATENCY))
    else $error("result without matching item");

  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && quat_o.invalid |-> quat_o.quat_x == '0 && quat_o.quat_y == '0 &&
                                 quat_o.quat_z == '0 && quat_o.quat_w == '0)
    else $error("invalid result with nonzero components");

  a_trace_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && quat_o.invalid |-> $past(trace, LATENCY) <= 0)
    else $error("trace path flagged invalid");

endmodule

bind rotation_matrix_to_quaternion rm2q_checker u_rm2q_checker (.*);

// ===== bench/tb_rotation_matrix_to_quaternion.sv =====
// ----------------------------------------------------------------------------
// tb_rotation_matrix_to_quaternion
// Drives rotation matrices into the quaternion block and compares every
// result against an in-bench fixed point predictor of the trace method.
// ----------------------------------------------------------------------------
module tb_rotation_matrix_to_quaternion;
  import rm2q_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint ONE     = longint'(1) << FRAC_BITS;
  localparam longint POS_LIM = (longint'(1) << (W - 1)) - 1;
  localparam longint NEG_LIM = longint'(1) << (W - 1);

  logic  clk_i = 1'b0;
  logic  rst_ni = 1'b0;
  logic  start_i = 1'b0;
  mat_t  mat_i = '0;
  logic  busy_o;
  logic  done_o;
  quat_t quat_o;

  quat_t quat_q[$];
  int    errors = 0;
  int    send_idle_pct = 0;

  rotation_matrix_to_quaternion dut (.*);

  always #6 clk_i = ~clk_i;

  function automatic longint unsigned isqrt_fx(longint unsigned r);
    longint unsigned rem, root, trial;
    longint unsigned v;
    rem = 0;
    root = 0;
    v = r << FRAC_BITS;
    for (int k = PAIRS - 1; k >= 0; k--) begin
      rem = (rem << 2) | ((v >> (2 * k)) & 3);
      trial = (root << 2) | 1;
      if (rem >= trial) begin
        rem -= trial;
        root = (root << 1) | 1;
      end else begin
        root = root << 1;
      end
    end
    return root;
  endfunction

  function automatic logic [W-1:0] clamp(longint unsigned mag, bit neg);
    if (neg) return (mag >= NEG_LIM) ? W'(-NEG_LIM) : W'(-longint'(mag));
    return (mag > POS_LIM) ? W'(POS_LIM) : W'(mag);
  endfunction

  function automatic logic [W-1:0] scale(longint d, longint unsigned h);
    bit neg;
    logic [127:0] p;
    neg = d < 0;
    p = 128'(neg ? -d : d) * 128'(h);
    p = p >> FRAC_BITS;
    if (p[127:63] != 0) return clamp(64'hffff_ffff_ffff_ffff, neg);
    return clamp(p[63:0], neg);
  endfunction

  function automatic quat_t predict_quat(mat_t m);
    longint e0, e1, e2, e4, e5, e6, e8, e9, e10, tr, r;
    longint unsigned root, h;
    logic [1:0] br;
    quat_t q;
    e0 = m.mat_e0; e1 = m.mat_e1; e2 = m.mat_e2;
    e4 = m.mat_e4; e5 = m.mat_e5; e6 = m.mat_e6;
    e8 = m.mat_e8; e9 = m.mat_e9; e10 = m.mat_e10;
    q = '0;
    tr = e0 + e5 + e10;
    if (tr > 0) begin
      br = BR_W; r = tr + ONE;
    end else if (e0 >= e5 && e0 >= e10) begin
      br = BR_X; r = ONE + e0 - e5 - e10;
    end else if (e5 > e10) begin
      br = BR_Y; r = ONE + e5 - e0 - e10;
    end else begin
      br = BR_Z; r = ONE + e10 - e0 - e5;
    end
    if (r <= 0) begin
      q.invalid = 1'b1;
      return q;
    end
    root = isqrt_fx(r);
    h = (root != 0) ? (longint'(1) << (2 * FRAC_BITS - 1)) / root : '1;
    case (br)
      BR_W: begin
        q.quat_x = scale(e6 - e9, h);
        q.quat_y = scale(e8 - e2, h);
        q.quat_z = scale(e1 - e4, h);
        q.quat_w = clamp(root >> 1, 1'b0);
      end
      BR_X: begin
        q.quat_x = clamp(root >> 1, 1'b0);
        q.quat_y = scale(e1 + e4, h);
        q.quat_z = scale(e2 + e8, h);
        q.quat_w = scale(e6 - e9, h);
      end
      BR_Y: begin
        q.quat_x = scale(e4 + e1, h);
        q.quat_y = clamp(root >> 1, 1'b0);
        q.quat_z = scale(e9 + e6, h);
        q.quat_w = scale(e8 - e2, h);
      end
      default: begin
        q.quat_x = scale(e8 + e2, h);
        q.quat_y = scale(e9 + e6, h);
        q.quat_z = clamp(root >> 1, 1'b0);
        q.quat_w = scale(e1 - e4, h);
      end
    endcase
    return q;
  endfunction

  task automatic send_mat(mat_t m);
    while ($urandom_range(99) < send_idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i <= 1'b1;
    mat_i   <= m;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    quat_q.push_back(predict_quat(m));
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (quat_q.size() == 0) begin
        $error("unexpected result %h", quat_o);
        errors++;
      end else begin
        quat_t e;
        e = quat_q.pop_front();
        if (quat_o.quat_x !== e.quat_x) begin
          $error("quat_x exp %0d got %0d", e.quat_x, quat_o.quat_x); errors++;
        end
        if (quat_o.quat_y !== e.quat_y) begin
          $error("quat_y exp %0d got %0d", e.quat_y, quat_o.quat_y); errors++;
        end
        if (quat_o.quat_z !== e.quat_z) begin
          $error("quat_z exp %0d got %0d", e.quat_z, quat_o.quat_z); errors++;
        end
        if (quat_o.quat_w !== e.quat_w) begin
          $error("quat_w exp %0d got %0d", e.quat_w, quat_o.quat_w); errors++;
        end
        if (quat_o.invalid !== e.invalid) begin
          $error("invalid exp %0b got %0b", e.invalid, quat_o.invalid); errors++;
        end
      end
    end
  end

  function automatic logic [W-1:0] rand_elem();
    case ($urandom_range(5))
      0: return W'(NEG_LIM);
      1: return W'(POS_LIM);
      2: return W'($urandom_range(2 * ONE) - ONE);
      default: return W'($urandom);
    endcase
  endfunction

  function automatic mat_t rand_mat();
    mat_t m;
    m.mat_e0 = rand_elem(); m.mat_e1 = rand_elem(); m.mat_e2 = rand_elem();
    m.mat_e4 = rand_elem(); m.mat_e5 = rand_elem(); m.mat_e6 = rand_elem();
    m.mat_e8 = rand_elem(); m.mat_e9 = rand_elem(); m.mat_e10 = rand_elem();
    return m;
  endfunction

  function automatic mat_t diag_mat(longint a, longint b, longint c);
    mat_t m;
    m = rand_mat();
    m.mat_e0 = W'(a); m.mat_e5 = W'(b); m.mat_e10 = W'(c);
    return m;
  endfunction

  task automatic drain_results();
    start_i <= 1'b0;
    while (quat_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_directed();
    mat_t m;
    send_idle_pct = 0;
    m = '0;
    m.mat_e0 = W'(ONE); m.mat_e5 = W'(ONE); m.mat_e10 = W'(ONE);
    send_mat(m);                                   // identity
    send_mat('0);                                  // zero trace, e0 branch
    m = '0;
    m.mat_e0 = W'(ONE); m.mat_e5 = W'(-ONE); m.mat_e10 = W'(-ONE);
    send_mat(m);                                   // x branch
    m.mat_e0 = W'(-ONE); m.mat_e5 = W'(ONE);
    send_mat(m);                                   // y branch
    m.mat_e5 = W'(-ONE); m.mat_e10 = W'(ONE);
    send_mat(m);                                   // z branch
    send_mat(diag_mat(-ONE, ONE, ONE));            // tie e5 == e10, positive trace, w branch
    send_mat(diag_mat(-NEG_LIM, -NEG_LIM, -NEG_LIM)); // all diagonals at the negative limit, x branch
    send_mat(diag_mat(-ONE, 0, ONE));              // zero trace, z branch
    send_mat(diag_mat(0, 0, 1));                   // tiny positive trace
    send_mat(diag_mat(POS_LIM, POS_LIM, POS_LIM)); // largest trace
    send_mat(diag_mat(-NEG_LIM, POS_LIM, -NEG_LIM));
    send_mat(diag_mat(-NEG_LIM, -NEG_LIM, POS_LIM));
    send_mat(diag_mat(POS_LIM, -NEG_LIM, -NEG_LIM));
    m = '1;
    send_mat(m);
    m = '0;
    m.mat_e1 = W'(POS_LIM); m.mat_e4 = W'(POS_LIM);
    m.mat_e2 = W'(-NEG_LIM); m.mat_e8 = W'(-NEG_LIM);
    m.mat_e6 = W'(POS_LIM); m.mat_e9 = W'(-NEG_LIM);
    m.mat_e0 = 1;
    send_mat(m);                                   // saturating products
    m.mat_e0 = 0; m.mat_e10 = 1;
    send_mat(m);
    drain_results();
  endtask

  task automatic test_random(int n, int idle);
    send_idle_pct = idle;
    for (int i = 0; i < n; i++) send_mat(rand_mat());
    send_idle_pct = 0;
  endtask

  task automatic test_pause_drain();
    test_random(20, 0);
    drain_results();
    test_random(20, 0);
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(500, 0);
    test_random(450, 75);
    test_random(400, 0);
    test_pause_drain();
    test_random(450, 29);
    start_i <= 1'b0;
    @(posedge clk_i);
    fork
      drain_results();
      repeat (20000) @(posedge clk_i);
    join_any
    disable fork;
    if (quat_q.size() != 0) errors++;
    repeat (LATENCY + 10) @(posedge clk_i);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("tb: failure");
    $finish;
  end

endmodule
